FILE: hw/rtl/smoke_fire_alarm_hysteresis_top_macros.svh
// Assertion macros shared by the alarm RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SMOKE_FIRE_ALARM_HYSTERESIS_TOP_MACROS_SVH
`define SMOKE_FIRE_ALARM_HYSTERESIS_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SFAH_ASSERT_HOLDS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("alarm invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define SFAH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alarm sequencing violated");

`endif

FILE: hw/rtl/sfah_pkg.sv
// Shared types and constants for the smoke/fire alarm with hysteresis.
// No dependencies; used by the channel interfaces, sfah_core and the top level.
package sfah_pkg;

  localparam int CMD_W   = 3;
  localparam int LEVEL_W = 8;
  localparam int THR_W   = 7;

  localparam logic [THR_W-1:0] LOW_RESET  = 7'd50;
  localparam logic [THR_W-1:0] HIGH_RESET = 7'd60;
  localparam logic [THR_W-1:0] HIGH_MAX   = 7'd100;
  localparam logic [THR_W-1:0] LOW_MAX    = 7'd99;
  localparam logic [THR_W-1:0] HIGH_MIN   = 7'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE   = 3'd0,
    CMD_RAISE  = 3'd1,
    CMD_LOWER  = 3'd2,
    CMD_MUTE   = 3'd3,
    CMD_SELECT = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [THR_W-1:0] lower;
    logic [THR_W-1:0] upper;
    logic             select_upper;
    logic             mute;
    logic             relay;
    logic             buzzer;
  } alarm_state_t;

endpackage

FILE: hw/rtl/sfah_in_if.sv
// Input channel: command, smoke reading and flame flag with valid/ready.
// Depends on sfah_pkg for field widths.
interface sfah_in_if;
  logic                              valid;
  logic                              ready;
  logic [sfah_pkg::CMD_W-1:0]        cmd;
  logic [sfah_pkg::LEVEL_W-1:0]      smoke_level;
  logic                              fire_detected;

  modport source (output valid, cmd, smoke_level, fire_detected, input ready);
  modport sink   (input valid, cmd, smoke_level, fire_detected, output ready);
endinterface

FILE: hw/rtl/sfah_out_if.sv
// Result channel: alarm drives, thresholds and mode flags with valid/ready.
// Depends on sfah_pkg for field widths.
interface sfah_out_if;
  logic                         valid;
  logic                         ready;
  logic                         relay_on;
  logic                         buzzer_on;
  logic [sfah_pkg::THR_W-1:0]   low_level;
  logic [sfah_pkg::THR_W-1:0]   high_level;
  logic                         editing_high;
  logic                         silenced;

  modport source (output valid, relay_on, buzzer_on, low_level, high_level,
                  editing_high, silenced, input ready);
  modport sink   (input valid, relay_on, buzzer_on, low_level, high_level,
                  editing_high, silenced, output ready);
endinterface

FILE: hw/rtl/sfah_core.sv
// Next-state logic of the alarm: command decode, threshold adjust, hysteresis.
// Pure combinational; depends on sfah_pkg.
module sfah_core (
  input  sfah_pkg::alarm_state_t          cur,
  input  logic [sfah_pkg::CMD_W-1:0]      cmd,
  input  logic [sfah_pkg::LEVEL_W-1:0]    smoke_level,
  input  logic                            fire_detected,
  output sfah_pkg::alarm_state_t          nxt
);

  localparam int TW = sfah_pkg::THR_W + 1;

  sfah_pkg::alarm_state_t      cmd_st;
  logic [TW-1:0]               lw;
  logic [TW-1:0]               uw;
  logic [TW-1:0]               t;
  logic [TW-1:0]               t2;
  logic                        trip;

  assign lw = {1'b0, cur.lower};
  assign uw = {1'b0, cur.upper};

  always_comb begin
    cmd_st = cur;
    t      = '0;
    t2     = '0;
    case (sfah_pkg::cmd_t'(cmd))
      sfah_pkg::CMD_RAISE: begin
        if (cur.select_upper) begin
          t = uw + TW'(1);
          cmd_st.upper = (t > {1'b0, sfah_pkg::HIGH_MAX}) ? sfah_pkg::HIGH_MAX
                                                         : t[TW-2:0];
        end else begin
          t = lw + TW'(1);
          if (t >= uw) begin
            t2 = t + TW'(1);
            cmd_st.upper = (t2 > {1'b0, sfah_pkg::HIGH_MAX}) ? sfah_pkg::HIGH_MAX
                                                            : t2[TW-2:0];
          end
          cmd_st.lower = (t > {1'b0, sfah_pkg::LOW_MAX}) ? sfah_pkg::LOW_MAX
                                                        : t[TW-2:0];
        end
      end
      sfah_pkg::CMD_LOWER: begin
        if (cur.select_upper) begin
          if (cur.upper == '0) begin
            cmd_st.lower = '0;
            cmd_st.upper = sfah_pkg::HIGH_MIN;
          end else begin
            t = uw - TW'(1);
            // push lower down so it stays below upper
            if (lw >= t) begin
              cmd_st.lower = (t == '0) ? '0 : t[TW-2:0] - sfah_pkg::THR_W'(1);
            end
            cmd_st.upper = (t == '0) ? sfah_pkg::HIGH_MIN : t[TW-2:0];
          end
        end else begin
          cmd_st.lower = (cur.lower == '0) ? '0 : cur.lower - sfah_pkg::THR_W'(1);
        end
      end
      sfah_pkg::CMD_MUTE: begin
        cmd_st.buzzer = 1'b0;
        cmd_st.mute   = ~cur.mute;
      end
      sfah_pkg::CMD_SELECT: begin
        cmd_st.select_upper = ~cur.select_upper;
      end
      default: begin
      end
    endcase
  end

  assign trip = (smoke_level >= {1'b0, cmd_st.upper}) || fire_detected;

  always_comb begin
    nxt = cmd_st;
    if (trip) begin
      nxt.relay = 1'b1;
      if (!cmd_st.mute) begin
        nxt.buzzer = 1'b1;
      end
    end else if (smoke_level < {1'b0, cmd_st.lower}) begin
      nxt.relay  = 1'b0;
      nxt.buzzer = 1'b0;
    end
  end

endmodule

FILE: hw/rtl/smoke_fire_alarm_hysteresis_top.sv
// Top level of the smoke/fire alarm with hysteresis: input register, state, result register.
// Depends on sfah_pkg, sfah_in_if, sfah_out_if, sfah_core and the assertion macros header.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------------
//  sample   | in  | cmd[2:0], smoke_level[7:0], fire_detected
//  status   | out | relay_on, buzzer_on, low_level[6:0], high_level[6:0],
//           |     | editing_high, silenced
//
// One transaction per cycle sustained while status is ready; a result is offered once its input
// transaction has passed the input register and then the result register.
// The state update is a single pass through sfah_core, so throughput is set by it.
// rst clears valid flags and loads thresholds 50/60, selection low, unmuted, outputs off.
// A stall on status holds the result register and the input register, and sample.ready
// drops only while both are full.
`include "smoke_fire_alarm_hysteresis_top_macros.svh"

module smoke_fire_alarm_hysteresis_top (
  input  logic        clk,
  input  logic        rst,
  sfah_in_if.sink     sample,
  sfah_out_if.source  status
);

  logic                              in_valid;
  logic [sfah_pkg::CMD_W-1:0]        in_cmd;
  logic [sfah_pkg::LEVEL_W-1:0]      in_level;
  logic                              in_fire;

  sfah_pkg::alarm_state_t            state;
  sfah_pkg::alarm_state_t            state_next;

  logic                              out_valid;
  logic                              advance;

  assign advance      = in_valid && (!out_valid || status.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  // capture payload on every accepted transaction
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_cmd   <= sample.cmd;
      in_level <= sample.smoke_level;
      in_fire  <= sample.fire_detected;
    end
  end

  sfah_core u_core (
    .cur           (state),
    .cmd           (in_cmd),
    .smoke_level   (in_level),
    .fire_detected (in_fire),
    .nxt           (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.lower        <= sfah_pkg::LOW_RESET;
      state.upper        <= sfah_pkg::HIGH_RESET;
      state.select_upper <= 1'b0;
      state.mute         <= 1'b0;
      state.relay        <= 1'b0;
      state.buzzer       <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  // the result register mirrors the state after each update
  assign status.valid        = out_valid;
  assign status.relay_on     = state.relay;
  assign status.buzzer_on    = state.buzzer;
  assign status.low_level    = state.lower;
  assign status.high_level   = state.upper;
  assign status.editing_high = state.select_upper;
  assign status.silenced     = state.mute;

  `SFAH_ASSERT_HOLDS(a_thr_ordered, state.lower < state.upper)
  `SFAH_ASSERT_HOLDS(a_thr_range, (state.upper <= sfah_pkg::HIGH_MAX) && (state.upper != '0))
  `SFAH_ASSERT_HOLDS(a_mute_quiet, !(state.mute && state.buzzer))
  `SFAH_ASSERT_HOLDS(a_buzz_relay, !state.buzzer || state.relay)
  `SFAH_ASSERT_NEXT(a_adv_result, advance, out_valid)

endmodule

FILE: bench/alarm_status_checker.sv
// Watches the sample and status channels of the alarm block, predicts each status
// transaction from the accepted samples and compares field by field.
// Depends on sfah_pkg, sfah_in_if and sfah_out_if.
module alarm_status_checker (
  input  logic clk,
  input  logic rst,
  sfah_in_if   smp,
  sfah_out_if  sts,
  output int   mismatches,
  output int   awaiting
);

  typedef struct packed {
    logic                       relay;
    logic                       buzzer;
    logic [sfah_pkg::THR_W-1:0] low;
    logic [sfah_pkg::THR_W-1:0] high;
    logic                       edit_high;
    logic                       muted;
  } alarm_status_t;

  alarm_status_t              status_due[$];
  logic [sfah_pkg::THR_W-1:0] thr_low;
  logic [sfah_pkg::THR_W-1:0] thr_high;
  logic                       pick_high;
  logic                       muted;
  logic                       relay;
  logic                       buzzer;

  function automatic alarm_status_t alarm_next(logic [sfah_pkg::CMD_W-1:0] code,
                                               logic [sfah_pkg::LEVEL_W-1:0] level,
                                               logic fire);
    alarm_status_t s;
    int lo;
    int hi;
    lo = int'(thr_low);
    hi = int'(thr_high);
    case (code)
      sfah_pkg::CMD_RAISE: begin
        if (pick_high) begin
          hi = (hi + 1 > int'(sfah_pkg::HIGH_MAX)) ? int'(sfah_pkg::HIGH_MAX) : hi + 1;
        end else begin
          lo = lo + 1;
          // push upper along so low stays below high
          if (lo >= hi)
            hi = (lo + 1 > int'(sfah_pkg::HIGH_MAX)) ? int'(sfah_pkg::HIGH_MAX) : lo + 1;
          if (lo > int'(sfah_pkg::LOW_MAX)) lo = int'(sfah_pkg::LOW_MAX);
        end
      end
      sfah_pkg::CMD_LOWER: begin
        if (pick_high) begin
          hi = hi - 1;
          if (lo >= hi) lo = (hi - 1 < 0) ? 0 : hi - 1;
          if (hi < int'(sfah_pkg::HIGH_MIN)) hi = int'(sfah_pkg::HIGH_MIN);
        end else begin
          lo = (lo - 1 < 0) ? 0 : lo - 1;
        end
      end
      sfah_pkg::CMD_MUTE: begin
        buzzer = 1'b0;
        muted  = !muted;
      end
      sfah_pkg::CMD_SELECT: pick_high = !pick_high;
      default: ;
    endcase
    thr_low  = lo[sfah_pkg::THR_W-1:0];
    thr_high = hi[sfah_pkg::THR_W-1:0];

    if (int'(level) >= hi || fire) begin
      if (!muted) buzzer = 1'b1;
      relay = 1'b1;
    end else if (int'(level) < lo) begin
      relay  = 1'b0;
      buzzer = 1'b0;
    end

    s.relay     = relay;
    s.buzzer    = buzzer;
    s.low       = thr_low;
    s.high      = thr_high;
    s.edit_high = pick_high;
    s.muted     = muted;
    return s;
  endfunction

  always @(posedge clk) begin
    alarm_status_t want;
    alarm_status_t got;
    if (rst) begin
      thr_low    = sfah_pkg::LOW_RESET;
      thr_high   = sfah_pkg::HIGH_RESET;
      pick_high  = 1'b0;
      muted      = 1'b0;
      relay      = 1'b0;
      buzzer     = 1'b0;
      mismatches = 0;
      status_due.delete();
    end else begin
      if (sts.valid && sts.ready) begin
        got = '{sts.relay_on, sts.buzzer_on, sts.low_level, sts.high_level,
                sts.editing_high, sts.silenced};
        if (status_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("extra status: relay %0b buzz %0b lo %0d hi %0d edit %0b mute %0b",
                     got.relay, got.buzzer, got.low, got.high, got.edit_high, got.muted);
        end else begin
          want = status_due.pop_front();
          if (got.relay !== want.relay || got.buzzer !== want.buzzer ||
              got.low !== want.low || got.high !== want.high ||
              got.edit_high !== want.edit_high || got.muted !== want.muted) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("status mismatch");
              $display("  exp relay %0b buzz %0b lo %0d hi %0d edit %0b mute %0b",
                       want.relay, want.buzzer, want.low, want.high, want.edit_high,
                       want.muted);
              $display("  got relay %0b buzz %0b lo %0d hi %0d edit %0b mute %0b",
                       got.relay, got.buzzer, got.low, got.high, got.edit_high,
                       got.muted);
            end
          end
        end
      end
      if (smp.valid && smp.ready)
        status_due.push_back(alarm_next(smp.cmd, smp.smoke_level, smp.fire_detected));
    end
    awaiting = status_due.size();
  end

endmodule

FILE: bench/tb_top.sv
// Stimulus and verdict for the smoke/fire alarm block; the checker does the prediction.
// Depends on sfah_pkg, sfah_in_if, sfah_out_if, alarm_status_checker and the RTL top.
module tb_top;

  localparam logic [sfah_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [sfah_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [sfah_pkg::CMD_W-1:0] CMD_SPARE_C = 3'd7;
  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 300000;

  logic clk;
  logic rst;
  int   sent;
  int   cycles;
  int   mismatches;
  int   awaiting;
  bit   held_off;
  int   hold_left;

  sfah_in_if  sample_ch ();
  sfah_out_if status_ch ();

  smoke_fire_alarm_hysteresis_top u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .status (status_ch)
  );

  alarm_status_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .smp        (sample_ch),
    .sts        (status_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Status sink: random stalls, a calm stretch, and one long hold-off to back up the block.
  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      status_ch.ready <= 1'b0;
    end else if (!held_off && sent >= 300) begin
      held_off = 1'b1;
      hold_left = 59;
      status_ch.ready <= 1'b0;
    end else begin
      status_ch.ready <= (sent >= 800 && sent < 1100) || ($urandom_range(99) >= 19);
    end
  end

  function automatic logic [sfah_pkg::LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 70) return sfah_pkg::LEVEL_W'($urandom_range(110));
    return sfah_pkg::LEVEL_W'($urandom_range(255));
  endfunction

  function automatic logic pick_fire();
    return $urandom_range(99) < 10;
  endfunction

  task automatic offer(input logic [sfah_pkg::CMD_W-1:0] code,
                       input logic [sfah_pkg::LEVEL_W-1:0] level, input logic fire);
    while (!(sent >= 700 && sent < 1000) && $urandom_range(99) < 19) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.cmd           <= code;
    sample_ch.smoke_level   <= level;
    sample_ch.fire_detected <= fire;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sent = sent + 1;
  endtask

  task automatic adjust_run(input logic [sfah_pkg::CMD_W-1:0] code, input int count);
    repeat (count) offer(code, pick_level(), pick_fire());
  endtask

  initial begin
    int r;
    logic [sfah_pkg::CMD_W-1:0] code;
    rst                     = 1'b1;
    cycles                  = 0;
    sent                    = 0;
    held_off                = 1'b0;
    hold_left               = 0;
    sample_ch.valid         = 1'b0;
    sample_ch.cmd           = sfah_pkg::CMD_NONE;
    sample_ch.smoke_level   = '0;
    sample_ch.fire_detected = 1'b0;
    status_ch.ready         = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: trip, hold, mute while alarming, fire, unused codes
    offer(sfah_pkg::CMD_NONE,   8'd0,   1'b0);
    offer(sfah_pkg::CMD_NONE,   8'd255, 1'b0);
    offer(sfah_pkg::CMD_NONE,   8'd55,  1'b0);
    offer(sfah_pkg::CMD_MUTE,   8'd255, 1'b0);
    offer(sfah_pkg::CMD_NONE,   8'd255, 1'b1);
    offer(sfah_pkg::CMD_MUTE,   8'd200, 1'b1);
    offer(sfah_pkg::CMD_NONE,   8'd49,  1'b0);
    offer(sfah_pkg::CMD_NONE,   8'd0,   1'b1);
    offer(sfah_pkg::CMD_NONE,   8'd50,  1'b0);
    offer(sfah_pkg::CMD_NONE,   8'd59,  1'b0);
    offer(sfah_pkg::CMD_NONE,   8'd60,  1'b0);
    offer(sfah_pkg::CMD_RAISE,  8'd127, 1'b0);
    offer(sfah_pkg::CMD_LOWER,  8'd128, 1'b0);
    offer(sfah_pkg::CMD_SELECT, 8'd0,   1'b0);
    offer(sfah_pkg::CMD_RAISE,  8'd0,   1'b0);
    offer(sfah_pkg::CMD_LOWER,  8'd61,  1'b0);
    offer(CMD_SPARE_A,          8'd170, 1'b0);
    offer(CMD_SPARE_B,          8'd85,  1'b1);
    offer(CMD_SPARE_C,          8'd254, 1'b0);
    offer(sfah_pkg::CMD_SELECT, 8'd0,   1'b0);
    offer(sfah_pkg::CMD_MUTE,   8'd0,   1'b0);
    offer(sfah_pkg::CMD_MUTE,   8'd0,   1'b0);

    // drive both thresholds into their clamps
    adjust_run(sfah_pkg::CMD_RAISE, 70);
    offer(sfah_pkg::CMD_SELECT, pick_level(), pick_fire());
    adjust_run(sfah_pkg::CMD_RAISE, 10);
    adjust_run(sfah_pkg::CMD_LOWER, 110);
    offer(sfah_pkg::CMD_SELECT, pick_level(), pick_fire());
    adjust_run(sfah_pkg::CMD_LOWER, 10);

    while (sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 30) begin
        if ($urandom_range(1)) offer(sfah_pkg::CMD_SELECT, pick_level(), pick_fire());
        adjust_run($urandom_range(1) ? sfah_pkg::CMD_RAISE : sfah_pkg::CMD_LOWER,
                   $urandom_range(1, 70));
      end else if (r < 45) begin
        offer(sfah_pkg::CMD_MUTE, pick_level(), pick_fire());
      end else begin
        code = sfah_pkg::CMD_W'($urandom_range(99) < 80 ? sfah_pkg::CMD_NONE
                                                        : $urandom_range(7));
        offer(code, pick_level(), pick_fire());
      end
    end

    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
